/* sv/ldd_pkg.sv */
// ----------------------------------------------------------------------------
// ldd_pkg
// Field widths, command codes and status codes of the lock deadlock detector.
// ----------------------------------------------------------------------------
package ldd_pkg;

  localparam int CMD_W       = 1;
  localparam int THREAD_ID_W = 4;
  localparam int LOCK_ID_W   = 6;
  localparam int STATUS_W    = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  localparam status_t ST_SUCCESS     = 2'd0;
  localparam status_t ST_OTHER       = 2'd1;
  localparam status_t ST_DEADLOCK    = 2'd2;
  localparam status_t ST_FREE_UNLOCK = 2'd3;

endpackage

/* sv/lock_deadlock_detector.sv */
// ----------------------------------------------------------------------------
// lock_deadlock_detector
// Lock manager: grants and frees locks, records waits and walks the
// wait-for chain to flag deadlock. Holder and wait tables live in two
// synchronous single-read-port memories.
// ----------------------------------------------------------------------------
// After reset the block clears both tables, one entry of each per cycle,
// holding in_stall_o high. Then it takes one word at a time. A word with an
// out-of-range index answers from the accept state; an unlock, a grant or an
// already-waiting request answers after the accept and the table read. A lock
// request on a lock held by another thread walks the chain, each hop being a
// wait-table read followed by a lock-table read, until the chain ends, comes
// back to the requester or reaches its step bound.
// The result word sits in an output register, so a finished word waiting on
// out_stall_i does not hold back the next request.
module lock_deadlock_detector #(
  parameter int NUM_THREADS = 16,
  parameter int NUM_LOCKS   = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ldd_pkg::CMD_W-1:0]        cmd_i,
  input  logic [ldd_pkg::THREAD_ID_W-1:0]  thread_id_i,
  input  logic [ldd_pkg::LOCK_ID_W-1:0]    lock_id_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ldd_pkg::STATUS_W-1:0]     status_o
);
  import ldd_pkg::*;

  localparam int TW       = $clog2(NUM_THREADS);
  localparam int LW       = $clog2(NUM_LOCKS);
  localparam int LkEntW   = TW + 1;
  localparam int WtEntW   = LW + 1;
  localparam int MaxDepth = (NUM_LOCKS > NUM_THREADS) ? NUM_LOCKS : NUM_THREADS;
  localparam int CW       = $clog2(MaxDepth);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WW,
    S_WL,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    clr_cnt_q, clr_cnt_d;
  logic             cmd_q, cmd_d;
  logic [TW-1:0]    req_t_q, req_t_d;
  logic [LW-1:0]    req_m_q, req_m_d;
  logic [TW-1:0]    step_q, step_d;
  status_t          res_q, res_d;
  logic             out_valid_q, out_valid_d;
  status_t          status_q, status_d;

  logic [LkEntW-1:0] lock_mem [NUM_LOCKS];
  logic [WtEntW-1:0] wait_mem [NUM_THREADS];
  logic [LkEntW-1:0] lk_rdata_q;
  logic [WtEntW-1:0] wt_rdata_q;

  logic              lk_we, wt_we;
  logic [LW-1:0]     lk_waddr, lk_raddr;
  logic [TW-1:0]     wt_waddr, wt_raddr;
  logic [LkEntW-1:0] lk_wdata;
  logic [WtEntW-1:0] wt_wdata;

  logic          lk_v, wt_v;
  logic [TW-1:0] lk_h;
  logic [LW-1:0] wt_l;
  logic [TW-1:0] in_t;
  logic [LW-1:0] in_m;
  logic          t_oor, m_oor, out_free, fin;
  status_t       fin_st;

  assign lk_v     = lk_rdata_q[TW];
  assign lk_h     = lk_rdata_q[TW-1:0];
  assign wt_v     = wt_rdata_q[LW];
  assign wt_l     = wt_rdata_q[LW-1:0];
  assign in_t     = TW'(thread_id_i);
  assign in_m     = LW'(lock_id_i);
  assign t_oor    = 32'(thread_id_i) >= NUM_THREADS;
  assign m_oor    = 32'(lock_id_i) >= NUM_LOCKS;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cmd_d       = cmd_q;
    req_t_d     = req_t_q;
    req_m_d     = req_m_q;
    step_d      = step_q;
    res_d       = res_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    lk_we       = 1'b0;
    lk_waddr    = req_m_q;
    lk_wdata    = '0;
    wt_we       = 1'b0;
    wt_waddr    = req_t_q;
    wt_wdata    = '0;
    lk_raddr    = in_m;
    wt_raddr    = in_t;
    fin         = 1'b0;
    fin_st      = ST_SUCCESS;
    case (state_q)
      S_CLEAR: begin
        lk_we    = 32'(clr_cnt_q) < NUM_LOCKS;
        lk_waddr = LW'(clr_cnt_q);
        wt_we    = 32'(clr_cnt_q) < NUM_THREADS;
        wt_waddr = TW'(clr_cnt_q);
        if (clr_cnt_q == CW'(MaxDepth - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          req_t_d = in_t;
          req_m_d = in_m;
          if (t_oor || m_oor) begin
            fin    = 1'b1;
            fin_st = (cmd_i == CMD_LOCK) ? ST_OTHER : ST_FREE_UNLOCK;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (cmd_q == CMD_UNLOCK) begin
          fin = 1'b1;
          if (!lk_v) begin
            fin_st = ST_FREE_UNLOCK;
          end else begin
            lk_we  = 1'b1;
            fin_st = ST_SUCCESS;
          end
        end else if (!lk_v) begin
          lk_we    = 1'b1;
          lk_wdata = {1'b1, req_t_q};
          wt_we    = 1'b1;
          fin      = 1'b1;
          fin_st   = ST_SUCCESS;
        end else if (wt_v && wt_l == req_m_q) begin
          fin    = 1'b1;
          fin_st = ST_OTHER;
        end else begin
          wt_we    = 1'b1;
          wt_wdata = {1'b1, req_m_q};
          if (lk_h == req_t_q) begin
            fin    = 1'b1;
            fin_st = ST_DEADLOCK;
          end else begin
            wt_raddr = lk_h;
            step_d   = TW'(1);
            state_d  = S_WW;
          end
        end
      end
      S_WW: begin
        if (!wt_v) begin
          fin    = 1'b1;
          fin_st = ST_OTHER;
        end else begin
          lk_raddr = wt_l;
          state_d  = S_WL;
        end
      end
      S_WL: begin
        if (!lk_v) begin
          fin    = 1'b1;
          fin_st = ST_OTHER;
        end else if (lk_h == req_t_q) begin
          fin    = 1'b1;
          fin_st = ST_DEADLOCK;
        end else if (step_q == TW'(NUM_THREADS - 1)) begin
          fin    = 1'b1;
          fin_st = ST_OTHER;
        end else begin
          step_d   = step_q + TW'(1);
          wt_raddr = lk_h;
          state_d  = S_WW;
        end
      end
      S_DONE: begin
        fin    = 1'b1;
        fin_st = res_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        status_d    = fin_st;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_st;
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      lock_mem[lk_waddr] <= lk_wdata;
    end
    lk_rdata_q <= lock_mem[lk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wait_mem[wt_waddr] <= wt_wdata;
    end
    wt_rdata_q <= wait_mem[wt_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_LOCK;
      req_t_q     <= '0;
      req_m_q     <= '0;
      step_q      <= '0;
      res_q       <= ST_SUCCESS;
      status_q    <= ST_SUCCESS;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      req_t_q     <= req_t_d;
      req_m_q     <= req_m_d;
      step_q      <= step_d;
      res_q       <= res_d;
      status_q    <= status_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

`ifndef NO_ASSERTIONS
  a_done_has_pending_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> out_valid_q)
    else $error("parked result without a pending output word");

  a_walk_step_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WL |-> 32'(step_q) < NUM_THREADS)
    else $error("chain walk ran past its step bound");

  a_dual_write_only_on_grant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_we && wt_we |-> state_q == S_CLEAR || (state_q == S_RD && cmd_q == CMD_LOCK))
    else $error("both tables written outside clear or grant");
`endif

endmodule
